[hw/rtl/lgrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int ROW_BITS   = 64;
	localparam int WIDTH_BITS = 7;
	localparam int NB_BITS    = 4;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64);
	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'(MAX_WIDTH);

	localparam logic [NB_BITS-1:0] LIFE_BIRTH   = NB_BITS'(3);
	localparam logic [NB_BITS-1:0] LIFE_SURVIVE = NB_BITS'(2);

	typedef struct packed {
		logic first;
		logic flush;
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic up;
		logic mid;
		logic dn;
	} cell_nb_t;

	typedef struct packed {
		logic [MAX_WIDTH-1:0] row;
		logic                 last;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/lgrs_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module lgrs_cell import lgrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      active,
	input  logic      row_bit,
	input  cell_nb_t  left,
	input  cell_nb_t  right,
	output cell_nb_t  nb_out,
	output logic      next_bit
);

	logic               above_q;
	logic               middle_q;
	logic [NB_BITS-1:0] count;

	// first row of a grid sees dead rows above and below; flush sees a dead row below
	always_comb begin
		nb_out.up  = ctl.first ? 1'b0 : above_q;
		nb_out.mid = ctl.first ? row_bit : middle_q;
		nb_out.dn  = (ctl.first || ctl.flush) ? 1'b0 : row_bit;
	end

	always_comb begin
		count = NB_BITS'(left.up) + NB_BITS'(nb_out.up) + NB_BITS'(right.up)
			+ NB_BITS'(left.mid) + NB_BITS'(right.mid)
			+ NB_BITS'(left.dn) + NB_BITS'(nb_out.dn) + NB_BITS'(right.dn);
		next_bit = active && ((count == LIFE_BIRTH)
			|| (nb_out.mid && (count == LIFE_SURVIVE)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctl.clear) begin
			above_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (ctl.shift) begin
			above_q  <= middle_q;
			middle_q <= row_bit;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lgrs_skid.sv]
`timescale 1ns / 1ps
`default_nettype none

module lgrs_skid import lgrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  result_t in_data,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;

	assign room      = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (out_v_q && !out_ready) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/life_generation_row_stencil_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// One generation of the B3/S23 life rule on a grid streamed one row per beat
// (bit i = column i). A row of per-column cells keeps the two previous rows;
// each beat but the first of a grid yields the next state of the row before
// it; rows are taken while the output stage has room. A row with tlast set
// also yields its own next state (tlast high), queued once the output stage
// has room; no input is taken until that beat is queued. A two-entry output
// stage lets the block take one more row while a result waits. Columns at or
// above grid_width (saturated at 64) read as dead and come out as zero.
module life_generation_row_stencil_top import lgrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ROW_BITS-1:0]   s_tdata,   // row_cells
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ROW_BITS-1:0]   m_tdata,   // next_row
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WIDTH_BITS-1:0] cfg_data   // grid_width
);

	logic [WIDTH_BITS-1:0] width_q;
	logic [WIDTH_BITS-1:0] width_sat;
	logic                  primed_q;
	logic                  flush_q;
	logic                  room;
	logic                  acc;
	logic                  produce;
	cell_ctl_t             ctl;
	result_t               res;
	result_t               out_res;
	logic [MAX_WIDTH-1:0]  active;
	logic [MAX_WIDTH-1:0]  row_in;
	logic [MAX_WIDTH-1:0]  next_row;
	cell_nb_t              nb [MAX_WIDTH];

	assign cfg_ready = 1'b1;
	assign width_sat = (width_q > WIDTH_MAX) ? WIDTH_MAX : width_q;

	assign s_tready = room && !flush_q;
	assign acc      = s_tvalid && s_tready;
	assign produce  = (flush_q && room) || (acc && (primed_q || s_tlast));

	always_comb begin
		ctl.first = !primed_q && !flush_q;
		ctl.flush = flush_q;
		ctl.shift = acc && (primed_q || !s_tlast);
		ctl.clear = flush_q && room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			primed_q <= 1'b0;
			flush_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				width_q <= cfg_data;
			end
			flush_q <= (flush_q && !room) || (acc && s_tlast && primed_q);
			if (acc) begin
				primed_q <= !s_tlast;
			end
		end
	end

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
		cell_nb_t left;
		cell_nb_t right;

		assign active[i] = WIDTH_BITS'(i) < width_sat;
		assign row_in[i] = s_tdata[i] && active[i];

		if (i == 0) begin : g_lo
			assign left = '0;
		end else begin : g_lo
			assign left = nb[i-1];
		end
		if (i == MAX_WIDTH - 1) begin : g_hi
			assign right = '0;
		end else begin : g_hi
			assign right = nb[i+1];
		end

		lgrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.active   (active[i]),
			.row_bit  (row_in[i]),
			.left     (left),
			.right    (right),
			.nb_out   (nb[i]),
			.next_bit (next_row[i])
		);
	end

	always_comb begin
		res.row  = next_row;
		res.last = flush_q || (acc && !primed_q && s_tlast);
	end

	lgrs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (produce),
		.in_data   (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = ROW_BITS'(out_res.row);
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

[hw/rtl/lgrs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lgrs_checker import lgrs_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [ROW_BITS-1:0]   s_tdata,
	input wire logic                  s_tlast,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [ROW_BITS-1:0]   m_tdata,
	input wire logic                  m_tlast,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [WIDTH_BITS-1:0] cfg_data
);

	logic [WIDTH_BITS-1:0] width_q;
	logic [WIDTH_BITS-1:0] width_sat;
	logic [ROW_BITS-1:0]   mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= cfg_data;
		end
	end

	assign width_sat = (width_q > WIDTH_MAX) ? WIDTH_MAX : width_q;

	always_comb begin
		for (int i = 0; i < ROW_BITS; i++) begin
			mask[i] = (i < MAX_WIDTH) && (WIDTH_BITS'(i) < width_sat);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	a_out_masked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata & ~mask) == '0)
		else $error("live cell outside active width");

	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast && !m_tvalid |=> m_tvalid)
		else $error("bottom row gave no result");

endmodule

bind life_generation_row_stencil_top lgrs_checker u_lgrs_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import lgrs_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE_CYC  = 8;
	localparam int TOTAL_ROWS  = 1050;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [ROW_BITS-1:0]   s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [ROW_BITS-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [WIDTH_BITS-1:0] cfg_data;

	// predictor state
	logic [WIDTH_BITS-1:0] grid_w = WIDTH_RESET;
	logic [ROW_BITS-1:0]   above_row = '0;
	logic [ROW_BITS-1:0]   middle_row = '0;
	int                    held_count = 0;

	result_t expected_rows[$];
	int      mismatches = 0;
	int      rows_sent = 0;
	int      rx_hold = 0;
	int      idle_cycles = 0;
	bit      burst = 0;

	life_generation_row_stencil_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [ROW_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
		int cols;
		cols = (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
		if (cols >= ROW_BITS)
			return '1;
		return (ROW_BITS'(1) << cols) - ROW_BITS'(1);
	endfunction

	function automatic logic [ROW_BITS-1:0] life_next(input logic [ROW_BITS-1:0] up,
			input logic [ROW_BITS-1:0] mid, input logic [ROW_BITS-1:0] dn,
			input logic [ROW_BITS-1:0] mask);
		logic [ROW_BITS-1:0] nb [8];
		logic [ROW_BITS-1:0] nxt;
		int cnt;
		nb[0] = up << 1;
		nb[1] = up;
		nb[2] = up >> 1;
		nb[3] = mid << 1;
		nb[4] = mid >> 1;
		nb[5] = dn << 1;
		nb[6] = dn;
		nb[7] = dn >> 1;
		nxt = '0;
		for (int i = 0; i < ROW_BITS; i++) begin
			cnt = 0;
			for (int k = 0; k < 8; k++)
				cnt += nb[k][i];
			if (cnt == LIFE_BIRTH || (mid[i] && cnt == LIFE_SURVIVE))
				nxt[i] = 1'b1;
		end
		return nxt & mask;
	endfunction

	task automatic predict_generation(input logic [ROW_BITS-1:0] row_in, input logic last_in);
		logic [ROW_BITS-1:0] mask;
		logic [ROW_BITS-1:0] row;
		result_t r;
		mask = width_mask(grid_w);
		row = row_in & mask;
		if (held_count == 0) begin
			if (last_in) begin
				r.row = life_next('0, row, '0, mask);
				r.last = 1'b1;
				expected_rows.push_back(r);
				above_row = '0;
				middle_row = '0;
			end else begin
				above_row = '0;
				middle_row = row;
				held_count = 1;
			end
		end else begin
			r.row = life_next((held_count >= 2) ? above_row : '0, middle_row, row, mask);
			r.last = 1'b0;
			expected_rows.push_back(r);
			if (last_in) begin
				r.row = life_next(middle_row, row, '0, mask);
				r.last = 1'b1;
				expected_rows.push_back(r);
				above_row = '0;
				middle_row = '0;
				held_count = 0;
			end else begin
				above_row = middle_row;
				middle_row = row;
				held_count = 2;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [ROW_BITS-1:0] got,
			input logic [ROW_BITS-1:0] want);
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// entered and left at a falling edge; tvalid stays high when the next gap is zero
	task automatic send_row(input logic [ROW_BITS-1:0] row, input logic last_in);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= row;
		s_tlast <= last_in;
		do @(posedge clk); while (!s_tready);
		predict_generation(row, last_in);
		rows_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic set_width(input logic [WIDTH_BITS-1:0] w);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		grid_w = w;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rows.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, '0);
			end else begin
				want = expected_rows.pop_front();
				if (m_tdata !== want.row)
					report_mismatch("next_row", m_tdata, want.row);
				if (m_tlast !== want.last)
					report_mismatch("last", ROW_BITS'(m_tlast), ROW_BITS'(want.last));
			end
			rx_hold = burst ? 0 : $urandom_range(0, 11);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL life_generation_row_stencil_top");
			$finish;
		end
	end

	task automatic test_single_row;
		send_row('1, 1'b1);
		send_row(64'h5555_5555_5555_5555, 1'b1);
		send_row(64'h8000_0000_0000_0001, 1'b1);
	endtask

	task automatic test_grid_edges;
		send_row(64'hC000_0000_0000_0003, 1'b0);
		send_row(64'hC000_0000_0000_0003, 1'b0);
		send_row(64'hC000_0000_0000_0003, 1'b1);
		send_row(64'h8000_0000_0000_0000, 1'b0);
		send_row(64'h8000_0000_0000_0000, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b1);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
	endtask

	task automatic test_width_extremes;
		set_width(WIDTH_BITS'(0));
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		set_width(WIDTH_BITS'(1));
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		set_width('1);
		send_row('1, 1'b0);
		send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		set_width(WIDTH_BITS'(3));
		send_row(64'hFFFF_FFFF_FFFF_FFF8, 1'b0);
		send_row('1, 1'b1);
	endtask

	task automatic test_width_mid_grid;
		set_width(WIDTH_MAX);
		send_row('1, 1'b0);
		set_width(WIDTH_BITS'(5));
		send_row('1, 1'b1);
	endtask

	task automatic test_random_grids;
		logic [ROW_BITS-1:0] row;
		int height;
		int phase_rows;
		while (rows_sent < TOTAL_ROWS) begin
			case ($urandom_range(0, 7))
				0:       set_width(WIDTH_BITS'($urandom_range(0, 3)));
				1, 2:    set_width(WIDTH_BITS'($urandom_range(1, MAX_WIDTH)));
				3:       set_width(WIDTH_BITS'($urandom_range(MAX_WIDTH + 1, 127)));
				default: set_width(WIDTH_MAX);
			endcase
			burst = ($urandom_range(0, 3) == 0);
			phase_rows = 0;
			while (phase_rows < 80) begin
				height = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
				for (int r = 0; r < height; r++) begin
					case ($urandom_range(0, 3))
						0: row = {$urandom, $urandom};
						1: row = {$urandom, $urandom} & {$urandom, $urandom};
						2: row = {$urandom, $urandom} | {$urandom, $urandom};
						default: row = ROW_BITS'(7) << $urandom_range(0, ROW_BITS - 1);
					endcase
					send_row(row, r == height - 1);
				end
				phase_rows += height;
			end
		end
		burst = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_single_row();
		test_grid_edges();
		test_width_extremes();
		test_width_mid_grid();
		test_random_grids();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS life_generation_row_stencil_top");
		else
			$display("FAIL life_generation_row_stencil_top");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lgrs_pkg.sv
hw/rtl/lgrs_cell.sv
hw/rtl/lgrs_skid.sv
hw/rtl/life_generation_row_stencil_top.sv
hw/rtl/lgrs_checker.sv
bench/tb_top.sv
